[design/tga_dec_pkg.sv]
// Shared types and constants of the TGA stream decoder.
package tga_dec_pkg;

  // Parse phases.
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_IDLE   = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_HDR_OK  = 2'd0;
  localparam logic [1:0] KIND_HDR_ERR = 2'd1;
  localparam logic [1:0] KIND_PIXEL   = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_CMAP  = 2'd1;
  localparam logic [1:0] ERR_TYPE  = 2'd2;
  localparam logic [1:0] ERR_DEPTH = 2'd3;

  // Header byte positions of interest.
  localparam logic [4:0] POS_ID_LEN   = 5'd0;
  localparam logic [4:0] POS_CMAP     = 5'd1;
  localparam logic [4:0] POS_TYPE     = 5'd2;
  localparam logic [4:0] POS_WIDTH_LO = 5'd12;
  localparam logic [4:0] POS_WIDTH_HI = 5'd13;
  localparam logic [4:0] POS_HGT_LO   = 5'd14;
  localparam logic [4:0] POS_HGT_HI   = 5'd15;
  localparam logic [4:0] POS_DEPTH    = 5'd16;
  localparam logic [4:0] POS_LAST     = 5'd17;

  // Image types and pixel depths.
  localparam logic [7:0] IMG_RGB  = 8'd2;
  localparam logic [7:0] IMG_GRAY = 8'd3;
  localparam logic [7:0] BPP_8    = 8'd8;
  localparam logic [7:0] BPP_16   = 8'd16;
  localparam logic [7:0] BPP_24   = 8'd24;
  localparam logic [7:0] BPP_32   = 8'd32;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } bgra_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  error_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    bgra_t       pix;
    logic        last_pixel;
  } result_t;

endpackage

[design/tga_stream_decoder_core.sv]
// Top level of the streaming decoder for uncompressed TGA images.
//
//  Channel | Direction | Handshake            | Word carries
//  --------+-----------+----------------------+------------------------------------------
//  in_     | input     | in_valid / in_ready  | one file byte and a start-of-file mark
//  out_    | output    | out_valid / out_ready| header verdict or one B,G,R,A pixel
//
// Each word is taken into an input register; when it advances, the parser state and,
// where the word completes something, the result register are updated, so a result
// is offered from the result register that follows the input register.
// One byte is accepted in every cycle as long as the result side keeps taking words.
// The width by height product for the pixel count is one combinational 16 by 16
// multiply in the header step.
// Reset (synchronous, active low) empties both registers and puts the parser at header
// byte 0; a stalled result holds both stages, and in_ready falls only when the input
// register is full and cannot move.
module tga_stream_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_file_byte,
  input  logic        in_start_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_error_code,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic        out_has_alpha,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [7:0]  out_alpha,
  output logic        out_last_pixel
);
  import tga_dec_pkg::*;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_sof_r;

  // Parser state.
  logic [1:0]  phase_r, phase_nxt;
  logic [4:0]  hpos_r, hpos_nxt;
  logic [7:0]  id_left_r, id_left_nxt;
  logic [7:0]  img_kind_r, img_kind_nxt;
  logic [7:0]  bpp_r, bpp_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [31:0] pix_left_r, pix_left_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [23:0] pbytes_r, pbytes_nxt;

  // Values seen by this word: a start-of-file mark wipes the state first.
  logic [1:0]  cur_phase;
  logic [4:0]  cur_hpos;
  logic [7:0]  cur_id_left;
  logic [7:0]  cur_img_kind;
  logic [7:0]  cur_bpp;
  logic [15:0] cur_width;
  logic [15:0] cur_height;
  logic [31:0] cur_pix_left;
  logic [1:0]  cur_bip;
  logic [23:0] cur_pbytes;

  // Result register.
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t res;
  logic    emit;

  logic    out_free;
  logic    adv;
  logic    depth_ok;
  logic    alpha_flag;
  bgra_t   pix;

  assign out_free = !out_valid_r || out_ready;
  assign adv      = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || adv;

  always_comb begin
    if (s1_sof_r) begin
      cur_phase    = PH_HEADER;
      cur_hpos     = '0;
      cur_id_left  = '0;
      cur_img_kind = '0;
      cur_bpp      = '0;
      cur_width    = '0;
      cur_height   = '0;
      cur_pix_left = '0;
      cur_bip      = '0;
      cur_pbytes   = '0;
    end else begin
      cur_phase    = phase_r;
      cur_hpos     = hpos_r;
      cur_id_left  = id_left_r;
      cur_img_kind = img_kind_r;
      cur_bpp      = bpp_r;
      cur_width    = width_r;
      cur_height   = height_r;
      cur_pix_left = pix_left_r;
      cur_bip      = bip_r;
      cur_pbytes   = pbytes_r;
    end
  end

  tga_dec_pixel_fmt u_fmt (
    .bpp         (cur_bpp),
    .pixel_bytes (cur_pbytes),
    .last_byte   (s1_byte_r),
    .pix         (pix)
  );

  // RGB accepts 16, 24 and 32 bits per pixel; gray only 8.
  always_comb begin
    if (cur_img_kind == IMG_RGB) begin
      depth_ok = (s1_byte_r == BPP_16) || (s1_byte_r == BPP_24) || (s1_byte_r == BPP_32);
    end else begin
      depth_ok = (s1_byte_r == BPP_8);
    end
  end

  assign alpha_flag = (cur_img_kind == IMG_RGB) && ((cur_bpp == BPP_16) || (cur_bpp == BPP_32));

  always_comb begin
    phase_nxt    = cur_phase;
    hpos_nxt     = cur_hpos;
    id_left_nxt  = cur_id_left;
    img_kind_nxt = cur_img_kind;
    bpp_nxt      = cur_bpp;
    width_nxt    = cur_width;
    height_nxt   = cur_height;
    pix_left_nxt = cur_pix_left;
    bip_nxt      = cur_bip;
    pbytes_nxt   = cur_pbytes;
    emit         = 1'b0;
    res.kind       = KIND_HDR_OK;
    res.error_code = ERR_NONE;
    res.has_alpha  = 1'b0;
    res.pix        = '0;
    res.last_pixel = 1'b0;

    unique case (cur_phase)
      PH_HEADER: begin
        hpos_nxt = cur_hpos + 5'd1;
        unique case (cur_hpos)
          POS_ID_LEN: id_left_nxt = s1_byte_r;
          POS_CMAP: begin
            if (s1_byte_r != 8'd0) begin
              phase_nxt      = PH_IDLE;
              emit           = 1'b1;
              res.kind       = KIND_HDR_ERR;
              res.error_code = ERR_CMAP;
            end
          end
          POS_TYPE: begin
            img_kind_nxt = s1_byte_r;
            if ((s1_byte_r != IMG_RGB) && (s1_byte_r != IMG_GRAY)) begin
              phase_nxt      = PH_IDLE;
              emit           = 1'b1;
              res.kind       = KIND_HDR_ERR;
              res.error_code = ERR_TYPE;
            end
          end
          POS_WIDTH_LO: width_nxt  = {cur_width[15:8], s1_byte_r};
          POS_WIDTH_HI: width_nxt  = {s1_byte_r, cur_width[7:0]};
          POS_HGT_LO:   height_nxt = {cur_height[15:8], s1_byte_r};
          POS_HGT_HI:   height_nxt = {s1_byte_r, cur_height[7:0]};
          POS_DEPTH: begin
            bpp_nxt = s1_byte_r;
            if (!depth_ok) begin
              phase_nxt      = PH_IDLE;
              emit           = 1'b1;
              res.kind       = KIND_HDR_ERR;
              res.error_code = ERR_DEPTH;
            end
          end
          POS_LAST: begin
            pix_left_nxt = {16'd0, cur_width} * {16'd0, cur_height};
            bip_nxt      = '0;
            pbytes_nxt   = '0;
            if (cur_id_left != 8'd0) begin
              phase_nxt = PH_SKIP;
            end else if ((cur_width != 16'd0) && (cur_height != 16'd0)) begin
              phase_nxt = PH_PIXELS;
            end else begin
              phase_nxt = PH_IDLE;
            end
            emit          = 1'b1;
            res.kind      = KIND_HDR_OK;
            res.has_alpha = alpha_flag;
          end
          default: ;
        endcase
      end
      PH_SKIP: begin
        id_left_nxt = cur_id_left - 8'd1;
        if (id_left_nxt == 8'd0) begin
          phase_nxt = (cur_pix_left != 32'd0) ? PH_PIXELS : PH_IDLE;
        end
      end
      PH_PIXELS: begin
        if (({3'd0, cur_bip} + 5'd1) < cur_bpp[7:3]) begin
          // Still gathering bytes of this pixel.
          pbytes_nxt = cur_pbytes | ({16'd0, s1_byte_r} << {cur_bip, 3'b000});
          bip_nxt    = cur_bip + 2'd1;
        end else begin
          bip_nxt        = '0;
          pbytes_nxt     = '0;
          pix_left_nxt   = cur_pix_left - 32'd1;
          emit           = 1'b1;
          res.kind       = KIND_PIXEL;
          res.has_alpha  = alpha_flag;
          res.pix        = pix;
          res.last_pixel = (pix_left_nxt == 32'd0);
          if (pix_left_nxt == 32'd0) begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_IDLE: ;
      default: ;
    endcase

    res.image_width  = width_nxt;
    res.image_height = height_nxt;
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || (adv && emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_HEADER;
      hpos_r      <= '0;
      id_left_r   <= '0;
      img_kind_r  <= '0;
      bpp_r       <= '0;
      width_r     <= '0;
      height_r    <= '0;
      pix_left_r  <= '0;
      bip_r       <= '0;
      pbytes_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        phase_r    <= phase_nxt;
        hpos_r     <= hpos_nxt;
        id_left_r  <= id_left_nxt;
        img_kind_r <= img_kind_nxt;
        bpp_r      <= bpp_nxt;
        width_r    <= width_nxt;
        height_r   <= height_nxt;
        pix_left_r <= pix_left_nxt;
        bip_r      <= bip_nxt;
        pbytes_r   <= pbytes_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_file_byte;
      s1_sof_r  <= in_start_of_file;
    end
    if (adv && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_res_r.kind;
  assign out_error_code   = out_res_r.error_code;
  assign out_image_width  = out_res_r.image_width;
  assign out_image_height = out_res_r.image_height;
  assign out_has_alpha    = out_res_r.has_alpha;
  assign out_blue         = out_res_r.pix.blue;
  assign out_green        = out_res_r.pix.green;
  assign out_red          = out_res_r.pix.red;
  assign out_alpha        = out_res_r.pix.alpha;
  assign out_last_pixel   = out_res_r.last_pixel;

  // The final pixel of an image always leaves the parser idle.
  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit && res.last_pixel) |=> (phase_r == PH_IDLE))
    else $error("parser not idle after the last pixel");

  // While pixels are gathered the byte counter stays below the pixel size.
  a_bip_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PIXELS) |-> ({3'd0, bip_r} < bpp_r[7:3]))
    else $error("byte counter beyond the pixel size");

  // A held input word is not lost while the result side stalls.
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(s1_sof_r)))
    else $error("input register dropped a stalled word");

endmodule

[design/tga_dec_pixel_fmt.sv]
// Pixel formatter: turns the gathered bytes of one pixel into B,G,R,A.
module tga_dec_pixel_fmt (
  input  logic [7:0]          bpp,
  input  logic [23:0]         pixel_bytes,
  input  logic [7:0]          last_byte,
  output tga_dec_pkg::bgra_t  pix
);
  import tga_dec_pkg::*;

  logic [15:0] argb;

  // A 16-bit pixel is the stored low byte plus the byte arriving now.
  assign argb = {last_byte, pixel_bytes[7:0]};

  always_comb begin
    priority if (bpp == BPP_8) begin
      pix = '{blue: last_byte, green: last_byte, red: last_byte, alpha: 8'hFF};
    end else if (bpp == BPP_16) begin
      pix.blue  = {argb[4:0], 3'b000};
      pix.green = {argb[9:5], 3'b000};
      pix.red   = {argb[14:10], 3'b000};
      pix.alpha = argb[15] ? 8'hFF : 8'h00;
    end else if (bpp == BPP_24) begin
      pix = '{blue: pixel_bytes[7:0], green: pixel_bytes[15:8],
              red: last_byte, alpha: 8'hFF};
    end else begin
      pix = '{blue: pixel_bytes[7:0], green: pixel_bytes[15:8],
              red: pixel_bytes[23:16], alpha: last_byte};
    end
  end

endmodule
